// ===== src/xed_pkg.sv =====
// Shared types, constants and character helpers for the XML entity decoder.
package xed_pkg;

  // Default buffered entity name depth
  localparam int unsigned MAX_NAME_DEF = 32;

  // Characters with special meaning
  localparam logic [7:0] CH_AMP  = 8'h26;  // '&'
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
  localparam logic [7:0] CH_HASH = 8'h23;  // '#'
  localparam logic [7:0] CH_LT   = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT   = 8'h3E;  // '>'
  localparam logic [7:0] CH_QUOT = 8'h22;  // '"'
  localparam logic [7:0] CH_APOS = 8'h27;  // '''

  // Code point limits
  localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
  localparam logic [31:0] SURR_LO    = 32'h0000_D800;
  localparam logic [31:0] SURR_HI    = 32'h0000_DFFF;
  localparam logic [31:0] UTF_1B_MAX = 32'h0000_007F;
  localparam logic [31:0] UTF_2B_MAX = 32'h0000_07FF;
  localparam logic [31:0] UTF_3B_MAX = 32'h0000_FFFF;
  localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF_LEAD4  = 8'hF0;
  localparam logic [7:0]  UTF_CONT   = 8'h80;

  // Named entities: amp, lt, gt, quot, apos (lower case, zero padded)
  localparam int unsigned NUM_NAMED = 5;
  localparam logic [7:0] NAMED_LIT [NUM_NAMED][4] = '{
    '{8'h61, 8'h6D, 8'h70, 8'h00},  // amp
    '{8'h6C, 8'h74, 8'h00, 8'h00},  // lt
    '{8'h67, 8'h74, 8'h00, 8'h00},  // gt
    '{8'h71, 8'h75, 8'h6F, 8'h74},  // quot
    '{8'h61, 8'h70, 8'h6F, 8'h73}   // apos
  };
  localparam logic [2:0] NAMED_LEN [NUM_NAMED] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd4};
  localparam logic [7:0] NAMED_CHAR [NUM_NAMED] = '{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS};

  // Source of the byte loaded into the output register
  typedef enum logic [2:0] {
    SRC_IN   = 3'd0,
    SRC_AMP  = 3'd1,
    SRC_NAME = 3'd2,
    SRC_TAIL = 3'd3,
    SRC_CP   = 3'd4,
    SRC_MARK = 3'd5
  } out_src_e;

  // Byte captured into the tail register
  typedef enum logic [1:0] {
    TAIL_IN    = 2'd0,
    TAIL_SEMI  = 2'd1,
    TAIL_NAMED = 2'd2
  } tail_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      start;       // open a new entity
    logic      append;      // buffer the input byte
    logic      close;       // drop the buffered name
    logic      cap;         // input transaction taken
    logic      tail_load;
    tail_sel_e tail_sel;
    logic      k_clr;
    logic      k_inc;
    logic      out_load;
    out_src_e  out_src;
    logic      out_last;
    logic      out_text_end;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_amp;
    logic in_semi;
    logic in_name;
    logic len_full;
    logic raw_empty;
    logic name_done;
    logic named_hit;
    logic num_ok;
    logic cp_drop;
    logic cp_last;
  } sts_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) r = c | 8'h20;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_x(input logic [7:0] c);
    return c inside {8'h78, 8'h58};
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return c inside {CH_HASH, [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) r = {1'b1, c[3:0]};
    else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

// ===== src/xml_entity_decoder_top.sv =====
// Top level of the XML entity decoder with streaming ports.
// Decodes XML character entities in a byte stream to UTF-8. A plain text byte
// is taken and shown on the output in the next cycle, one per cycle while the
// output side keeps up. An opening '&' and each buffered name character
// produce nothing unless they end the text. When an entity closes or breaks,
// the input stalls while the results go out one byte per cycle, as long as the
// output side keeps up, through the single output register (up to 4 bytes for a
// numeric reference, 1 for a named one, up to MaxName + 2 for a verbatim flush
// from the name buffer). Every transaction that emits bytes ends with tlast set;
// a dropped code point at the end of text yields a marker with tuser[0] low.
module xml_entity_decoder_top #(
  parameter int unsigned MaxName = xed_pkg::MAX_NAME_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_text
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // run_last
  output logic [1:0] m_axis_tuser    // [0] byte_valid, [1] text_end
);

  xed_pkg::cmd_t cmd;
  xed_pkg::sts_t sts;
  logic          out_byte_valid;
  logic          out_text_end;

  xed_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  xed_datapath #(
    .MaxName (MaxName)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_byte_i        (s_axis_tdata),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_byte_o       (m_axis_tdata),
    .out_byte_valid_o (out_byte_valid),
    .out_run_last_o   (m_axis_tlast),
    .out_text_end_o   (out_text_end)
  );

  assign m_axis_tuser = {out_text_end, out_byte_valid};

endmodule

// ===== src/xed_datapath.sv =====
// Datapath: name buffer, numeric accumulator, named-entity matching and output register.
module xed_datapath #(
  parameter int unsigned MaxName = xed_pkg::MAX_NAME_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    in_byte_i,
  input  xed_pkg::cmd_t cmd_i,
  output xed_pkg::sts_t sts_o,
  output logic [7:0]    out_byte_o,
  output logic          out_byte_valid_o,
  output logic          out_run_last_o,
  output logic          out_text_end_o
);

  localparam int unsigned LenW = $clog2(MaxName + 1);
  localparam int unsigned IdxW = $clog2(MaxName);

  logic [LenW-1:0] name_len_q, name_len_d;
  logic [LenW-1:0] raw_len_q, raw_len_d;
  logic [LenW-1:0] k_q, k_d;
  logic [31:0]     accum_q, accum_d;
  logic            ok_q, ok_d;
  logic            hash_q, hash_d;
  logic            hex_q, hex_d;
  logic [xed_pkg::NUM_NAMED-1:0] match_q, match_d;
  logic [7:0]      lc;
  logic [4:0]      hv;

  logic [7:0]      name_mem [MaxName];
  logic [7:0]      rd_q;
  logic [7:0]      tail_q;
  logic [7:0]      named_char;
  logic [xed_pkg::NUM_NAMED-1:0] hit_vec;
  logic [2:0]      cp_n;
  logic [7:0]      cp_byte;
  logic [7:0]      out_byte_q;
  logic            out_valid_q, out_last_q, out_te_q;

  // Entity collection state update
  always_comb begin
    lc         = xed_pkg::to_lower(in_byte_i);
    hv         = xed_pkg::hex_val(in_byte_i);
    name_len_d = name_len_q;
    accum_d    = accum_q;
    ok_d       = ok_q;
    hash_d     = hash_q;
    hex_d      = hex_q;
    match_d    = match_q;
    if (cmd_i.append) begin
      if (name_len_q == '0) begin
        accum_d = '0;
        ok_d    = 1'b1;
        hash_d  = (in_byte_i == xed_pkg::CH_HASH);
        hex_d   = 1'b0;
        for (int i = 0; i < xed_pkg::NUM_NAMED; i++) begin
          match_d[i] = (lc == xed_pkg::NAMED_LIT[i][0]);
        end
      end else begin
        for (int i = 0; i < xed_pkg::NUM_NAMED; i++) begin
          match_d[i] = match_q[i] && (name_len_q < LenW'(4))
                       && (lc == xed_pkg::NAMED_LIT[i][name_len_q[1:0]]);
        end
        if (name_len_q == LenW'(1)) begin
          // second character: x/X selects hex, else first decimal digit
          if (xed_pkg::is_x(in_byte_i)) hex_d = 1'b1;
          else if (xed_pkg::is_digit(in_byte_i)) accum_d = {28'd0, in_byte_i[3:0]};
          else ok_d = 1'b0;
        end else if (hex_q) begin
          if (!hv[4]) ok_d = 1'b0;
          else accum_d = {accum_q[27:0], hv[3:0]};
        end else begin
          // times ten as two shifts
          if (xed_pkg::is_digit(in_byte_i)) begin
            accum_d = (accum_q << 3) + (accum_q << 1) + {28'd0, in_byte_i[3:0]};
          end else begin
            ok_d = 1'b0;
          end
        end
      end
      name_len_d = name_len_q + LenW'(1);
    end
    if (cmd_i.start) begin
      accum_d    = '0;
      ok_d       = 1'b1;
      name_len_d = '0;
    end
    if (cmd_i.close) name_len_d = '0;
  end

  // Length of the name to flush and the emit index
  always_comb begin
    raw_len_d = raw_len_q;
    if (cmd_i.cap) raw_len_d = cmd_i.append ? name_len_q + LenW'(1) : name_len_q;
    k_d = k_q;
    if (cmd_i.k_clr) k_d = '0;
    else if (cmd_i.k_inc) k_d = k_q + LenW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_len_q <= '0;
      raw_len_q  <= '0;
      k_q        <= '0;
      accum_q    <= '0;
      ok_q       <= 1'b1;
      hash_q     <= 1'b0;
      hex_q      <= 1'b0;
      match_q    <= '0;
    end else begin
      name_len_q <= name_len_d;
      raw_len_q  <= raw_len_d;
      k_q        <= k_d;
      accum_q    <= accum_d;
      ok_q       <= ok_d;
      hash_q     <= hash_d;
      hex_q      <= hex_d;
      match_q    <= match_d;
    end
  end

  // Name buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) name_mem[name_len_q[IdxW-1:0]] <= in_byte_i;
    rd_q <= name_mem[k_d[IdxW-1:0]];
  end

  // Named entity lookup
  always_comb begin
    named_char = xed_pkg::CH_AMP;
    for (int i = 0; i < xed_pkg::NUM_NAMED; i++) begin
      hit_vec[i] = match_q[i] && (name_len_q == LenW'(xed_pkg::NAMED_LEN[i]));
    end
    for (int i = xed_pkg::NUM_NAMED - 1; i >= 0; i--) begin
      if (hit_vec[i]) named_char = xed_pkg::NAMED_CHAR[i];
    end
  end

  // UTF-8 encoder, one byte per index
  always_comb begin
    if (accum_q <= xed_pkg::UTF_1B_MAX)      cp_n = 3'd1;
    else if (accum_q <= xed_pkg::UTF_2B_MAX) cp_n = 3'd2;
    else if (accum_q <= xed_pkg::UTF_3B_MAX) cp_n = 3'd3;
    else                                     cp_n = 3'd4;
    cp_byte = accum_q[7:0];
    case ({cp_n, k_q[1:0]})
      {3'd2, 2'd0}: cp_byte = xed_pkg::UTF_LEAD2 | {3'd0, accum_q[10:6]};
      {3'd2, 2'd1}: cp_byte = xed_pkg::UTF_CONT | {2'd0, accum_q[5:0]};
      {3'd3, 2'd0}: cp_byte = xed_pkg::UTF_LEAD3 | {4'd0, accum_q[15:12]};
      {3'd3, 2'd1}: cp_byte = xed_pkg::UTF_CONT | {2'd0, accum_q[11:6]};
      {3'd3, 2'd2}: cp_byte = xed_pkg::UTF_CONT | {2'd0, accum_q[5:0]};
      {3'd4, 2'd0}: cp_byte = xed_pkg::UTF_LEAD4 | {5'd0, accum_q[20:18]};
      {3'd4, 2'd1}: cp_byte = xed_pkg::UTF_CONT | {2'd0, accum_q[17:12]};
      {3'd4, 2'd2}: cp_byte = xed_pkg::UTF_CONT | {2'd0, accum_q[11:6]};
      {3'd4, 2'd3}: cp_byte = xed_pkg::UTF_CONT | {2'd0, accum_q[5:0]};
      default:      cp_byte = accum_q[7:0];
    endcase
  end

  // Status toward the controller
  always_comb begin
    sts_o.in_amp    = (in_byte_i == xed_pkg::CH_AMP);
    sts_o.in_semi   = (in_byte_i == xed_pkg::CH_SEMI);
    sts_o.in_name   = xed_pkg::is_name_char(in_byte_i);
    sts_o.len_full  = (name_len_q == LenW'(MaxName));
    sts_o.raw_empty = (raw_len_q == '0);
    sts_o.name_done = ((k_q + LenW'(1)) == raw_len_q);
    sts_o.named_hit = |hit_vec;
    sts_o.num_ok    = hash_q && (name_len_q != '0) && ok_q && (accum_q != '0)
                      && (hex_q ? (name_len_q > LenW'(2)) : (name_len_q > LenW'(1)));
    sts_o.cp_drop   = (accum_q > xed_pkg::CP_MAX)
                      || ((accum_q >= xed_pkg::SURR_LO) && (accum_q <= xed_pkg::SURR_HI));
    sts_o.cp_last   = (k_q == LenW'(cp_n - 3'd1));
  end

  // Tail byte and output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.tail_load) begin
      case (cmd_i.tail_sel)
        xed_pkg::TAIL_IN:    tail_q <= in_byte_i;
        xed_pkg::TAIL_SEMI:  tail_q <= xed_pkg::CH_SEMI;
        xed_pkg::TAIL_NAMED: tail_q <= named_char;
        default:             tail_q <= in_byte_i;
      endcase
    end
    if (cmd_i.out_load) begin
      case (cmd_i.out_src)
        xed_pkg::SRC_IN:   out_byte_q <= in_byte_i;
        xed_pkg::SRC_AMP:  out_byte_q <= xed_pkg::CH_AMP;
        xed_pkg::SRC_NAME: out_byte_q <= rd_q;
        xed_pkg::SRC_TAIL: out_byte_q <= tail_q;
        xed_pkg::SRC_CP:   out_byte_q <= cp_byte;
        default:           out_byte_q <= 8'd0;
      endcase
      out_valid_q <= (cmd_i.out_src != xed_pkg::SRC_MARK);
      out_last_q  <= cmd_i.out_last;
      out_te_q    <= cmd_i.out_text_end;
    end
  end

  assign out_byte_o       = out_byte_q;
  assign out_byte_valid_o = out_valid_q;
  assign out_run_last_o   = out_last_q;
  assign out_text_end_o   = out_te_q;

endmodule

// ===== src/xed_ctrl.sv =====
// Controller: entity tracking, emit sequencing and output handshake.
module xed_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_last_i,
  output logic          s_ready_o,
  input  logic          m_ready_i,
  output logic          m_valid_o,
  input  xed_pkg::sts_t sts_i,
  output xed_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_AMP  = 7'b0000010,
    S_NAME = 7'b0000100,
    S_TAIL = 7'b0001000,
    S_CP   = 7'b0010000,
    S_AMP2 = 7'b0100000,
    S_MARK = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   in_ent_q, in_ent_d;
  logic   out_vld_q, out_vld_d;
  logic   last_q, last_d;
  logic   tail_q, tail_d;
  logic   amp2_q, amp2_d;
  logic   slot_free, accept, nothing_after;
  state_e after_name;

  assign slot_free     = !out_vld_q || m_ready_i;
  assign s_ready_o     = (state_q == S_IDLE) && slot_free;
  assign accept        = s_valid_i && s_ready_o;
  assign m_valid_o     = out_vld_q;
  assign nothing_after = !tail_q && !amp2_q;
  assign after_name    = tail_q ? S_TAIL : (amp2_q ? S_AMP2 : S_IDLE);

  always_comb begin
    state_d  = state_q;
    in_ent_d = in_ent_q;
    last_d   = last_q;
    tail_d   = tail_q;
    amp2_d   = amp2_q;
    cmd_o    = '0;
    case (state_q)
      // Take one input transaction and plan what it emits
      S_IDLE: begin
        if (accept) begin
          cmd_o.cap   = 1'b1;
          cmd_o.k_clr = 1'b1;
          last_d      = s_last_i;
          tail_d      = 1'b0;
          amp2_d      = 1'b0;
          if (!in_ent_q) begin
            if (sts_i.in_amp && s_last_i) begin
              cmd_o.out_load     = 1'b1;
              cmd_o.out_src      = xed_pkg::SRC_AMP;
              cmd_o.out_last     = 1'b1;
              cmd_o.out_text_end = 1'b1;
            end else if (sts_i.in_amp) begin
              cmd_o.start = 1'b1;
              in_ent_d    = 1'b1;
            end else begin
              cmd_o.out_load     = 1'b1;
              cmd_o.out_src      = xed_pkg::SRC_IN;
              cmd_o.out_last     = 1'b1;
              cmd_o.out_text_end = s_last_i;
            end
          end else if (sts_i.in_semi) begin
            cmd_o.close = 1'b1;
            in_ent_d    = 1'b0;
            if (sts_i.named_hit) begin
              cmd_o.tail_load = 1'b1;
              cmd_o.tail_sel  = xed_pkg::TAIL_NAMED;
              tail_d          = 1'b1;
              state_d         = S_TAIL;
            end else if (sts_i.num_ok) begin
              if (!sts_i.cp_drop) state_d = S_CP;
              else if (s_last_i)  state_d = S_MARK;
            end else begin
              cmd_o.tail_load = 1'b1;
              cmd_o.tail_sel  = xed_pkg::TAIL_SEMI;
              tail_d          = 1'b1;
              state_d         = S_AMP;
            end
          end else if (sts_i.in_name && !sts_i.len_full) begin
            cmd_o.append = 1'b1;
            if (s_last_i) begin
              cmd_o.close = 1'b1;
              in_ent_d    = 1'b0;
              state_d     = S_AMP;
            end
          end else begin
            // broken name: flush, then treat the byte as text
            cmd_o.close = 1'b1;
            state_d     = S_AMP;
            if (sts_i.in_amp) begin
              cmd_o.start = 1'b1;
              in_ent_d    = !s_last_i;
              amp2_d      = s_last_i;
            end else begin
              cmd_o.tail_load = 1'b1;
              cmd_o.tail_sel  = xed_pkg::TAIL_IN;
              tail_d          = 1'b1;
              in_ent_d        = 1'b0;
            end
          end
        end
      end
      S_AMP: begin
        if (slot_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_src      = xed_pkg::SRC_AMP;
          cmd_o.out_last     = sts_i.raw_empty && nothing_after;
          cmd_o.out_text_end = sts_i.raw_empty && nothing_after && last_q;
          state_d            = sts_i.raw_empty ? after_name : S_NAME;
        end
      end
      S_NAME: begin
        if (slot_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_src      = xed_pkg::SRC_NAME;
          cmd_o.k_inc        = 1'b1;
          cmd_o.out_last     = sts_i.name_done && nothing_after;
          cmd_o.out_text_end = sts_i.name_done && nothing_after && last_q;
          if (sts_i.name_done) state_d = after_name;
        end
      end
      S_TAIL: begin
        if (slot_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_src      = xed_pkg::SRC_TAIL;
          cmd_o.out_last     = !amp2_q;
          cmd_o.out_text_end = !amp2_q && last_q;
          state_d            = amp2_q ? S_AMP2 : S_IDLE;
        end
      end
      S_CP: begin
        if (slot_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_src      = xed_pkg::SRC_CP;
          cmd_o.k_inc        = 1'b1;
          cmd_o.out_last     = sts_i.cp_last;
          cmd_o.out_text_end = sts_i.cp_last && last_q;
          if (sts_i.cp_last) state_d = S_IDLE;
        end
      end
      S_AMP2: begin
        if (slot_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_src      = xed_pkg::SRC_AMP;
          cmd_o.out_last     = 1'b1;
          cmd_o.out_text_end = last_q;
          state_d            = S_IDLE;
        end
      end
      S_MARK: begin
        if (slot_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_src      = xed_pkg::SRC_MARK;
          cmd_o.out_last     = 1'b1;
          cmd_o.out_text_end = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register valid flag
  always_comb begin
    out_vld_d = out_vld_q && !m_ready_i;
    if (cmd_o.out_load) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      in_ent_q  <= 1'b0;
      out_vld_q <= 1'b0;
      last_q    <= 1'b0;
      tail_q    <= 1'b0;
      amp2_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_ent_q  <= in_ent_d;
      out_vld_q <= out_vld_d;
      last_q    <= last_d;
      tail_q    <= tail_d;
      amp2_q    <= amp2_d;
    end
  end

`ifndef SYNTHESIS
  // An entity never stays open past the end of the text
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_last_i) |=> !in_ent_q)
    else $error("entity still open after final byte");

  // The final byte of a sequence always returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_last && (state_q != S_IDLE)) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after last byte");

  // A marker only appears for the end of the text
  a_mark_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK) |-> last_q)
    else $error("marker outside end of text");

  // The name buffer is never written past its depth
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.append |-> !sts_i.len_full)
    else $error("append to full name buffer");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking stream testbench for the XML entity decoder top level.
module tb_top;

  localparam int unsigned NAME_MAX   = xed_pkg::MAX_NAME_DEF;
  localparam int unsigned RAND_ITEMS = 200;
  localparam int unsigned IDLE_PCT   = 38;
  localparam int unsigned HOLD_CYC   = 300;
  localparam int unsigned WD_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYC  = 2 * NAME_MAX + 16;
  localparam int unsigned MAX_SHOWN  = 10;
  localparam int unsigned N_DIR      = 28;

  // One output transaction: byte, byte_valid, run_last, text_end
  typedef struct packed {
    logic [7:0] data;
    logic       bvalid;
    logic       rlast;
    logic       tend;
  } out_item_t;

  // Directed row; the w_* fields hold a typed single result when typed is set
  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    logic       typed;
    logic [7:0] w_data;
    logic       w_valid;
    logic       w_rlast;
    logic       w_tend;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [N_DIR] = '{
    // byte extremes, the second one ending the text
    '{8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1},
    // mixed-case named entity
    '{"&", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"L", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"t", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{";", 1'b0, 1'b1, xed_pkg::CH_LT, 1'b1, 1'b1, 1'b0},
    // numeric reference without digits
    '{"&", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"#", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{";", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    // zero value reference
    '{"&", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"#", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"0", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{";", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    // surrogate code point at end of text leaves only the end marker
    '{"&", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"#", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"x", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"d", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"8", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"0", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"0", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{";", 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
    // name broken by a new '&', then the empty entity
    '{"&", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"a", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"&", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{";", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    // entity still open when the text ends
    '{"&", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"q", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{"b", 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] in_byte
  logic       s_axis_tlast;   // end_of_text
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic       m_axis_tlast;   // run_last
  logic [1:0] m_axis_tuser;   // [0] byte_valid, [1] text_end

  // Decoder state mirror
  logic            ent_open;
  logic [7:0]      name_buf [NAME_MAX];
  int unsigned     name_len;
  logic [31:0]     code_val;
  logic            digits_good;
  logic [7:0]      step_bytes [$];
  out_item_t       step_out [$];

  // Decoded bytes still owed by the block, oldest first
  out_item_t       decoded_due [$];

  // Random sequence under construction
  logic [7:0]      seq_bytes [$];
  logic            seq_end_last;
  string           name_set = "#0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
  string           hex_set  = "0123456789abcdef";

  bit              idle_on  = 1'b1;
  bit              hold_req = 1'b0;
  int unsigned     n_in, n_eot, n_out, n_bad, idle_run;

  xml_entity_decoder_top #(
    .MaxName(NAME_MAX)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_nc(input logic [7:0] c);
    return c == xed_pkg::CH_HASH || (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
           (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] lower_ch(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    if (step_bytes.size() < NAME_MAX + 2) step_bytes = {step_bytes, b};
  endfunction

  function automatic bit name_is(input string lit);
    if (name_len != lit.len()) return 1'b0;
    for (int k = 0; k < lit.len(); k++) begin
      if (lower_ch(name_buf[k]) != lit[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // '&' followed by the buffered name, as typed
  function automatic void spill_name();
    put_byte(xed_pkg::CH_AMP);
    for (int k = 0; k < name_len; k++) put_byte(name_buf[k]);
  endfunction

  function automatic void drop_ent();
    ent_open = 1'b0;
    name_len = 0;
  endfunction

  function automatic void text_in(input logic [7:0] b);
    if (b == xed_pkg::CH_AMP) begin
      ent_open    = 1'b1;
      name_len    = 0;
      code_val    = '0;
      digits_good = 1'b1;
    end else begin
      put_byte(b);
    end
  endfunction

  function automatic void put_utf8(input logic [31:0] cp);
    // out of range and surrogates vanish
    if (cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) return;
    if (cp <= 32'h7F) begin
      put_byte(cp[7:0]);
    end else if (cp <= 32'h7FF) begin
      put_byte({3'b110, cp[10:6]});
      put_byte({2'b10, cp[5:0]});
    end else if (cp <= 32'hFFFF) begin
      put_byte({4'b1110, cp[15:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end else begin
      put_byte({5'b11110, cp[20:18]});
      put_byte({2'b10, cp[17:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end
  endfunction

  // Buffer one name character and fold it into the numeric value
  function automatic void add_char(input logic [7:0] c);
    int v;
    if (name_len == 0) begin
      code_val    = '0;
      digits_good = 1'b1;
    end else if (name_len == 1) begin
      if (c != "x" && c != "X") begin
        if (c >= "0" && c <= "9") code_val = 32'(c) - 32'd48;
        else digits_good = 1'b0;
      end
    end else if (name_buf[1] == "x" || name_buf[1] == "X") begin
      v = hex_digit(c);
      if (v < 0) digits_good = 1'b0;
      else code_val = code_val * 32'd16 + 32'(v);
    end else begin
      if (c >= "0" && c <= "9") code_val = code_val * 32'd10 + (32'(c) - 32'd48);
      else digits_good = 1'b0;
    end
    name_buf[name_len] = c;
    name_len++;
  endfunction

  // Closing ';' seen
  function automatic void close_ent();
    bit hx, ok;
    if (name_is("amp")) put_byte(xed_pkg::CH_AMP);
    else if (name_is("lt")) put_byte(xed_pkg::CH_LT);
    else if (name_is("gt")) put_byte(xed_pkg::CH_GT);
    else if (name_is("quot")) put_byte(xed_pkg::CH_QUOT);
    else if (name_is("apos")) put_byte(xed_pkg::CH_APOS);
    else if (name_len >= 1 && name_buf[0] == xed_pkg::CH_HASH) begin
      hx = name_len >= 2 && (name_buf[1] == "x" || name_buf[1] == "X");
      ok = digits_good && (hx ? name_len > 2 : name_len > 1);
      if (ok && code_val != 0) begin
        put_utf8(code_val);
      end else begin
        spill_name();
        put_byte(xed_pkg::CH_SEMI);
      end
    end else begin
      spill_name();
      put_byte(xed_pkg::CH_SEMI);
    end
    drop_ent();
  endfunction

  // Results caused by one input byte, left in step_out
  function automatic void decode_step(input logic [7:0] b, input logic eot);
    out_item_t r;
    step_bytes.delete();
    step_out.delete();
    if (!ent_open) text_in(b);
    else if (b == xed_pkg::CH_SEMI) close_ent();
    else if (is_nc(b) && name_len < NAME_MAX) add_char(b);
    else begin
      spill_name();
      drop_ent();
      text_in(b);
    end
    if (eot && ent_open) begin
      spill_name();
      drop_ent();
    end
    if (step_bytes.size() == 0) begin
      if (eot) begin
        r = '{8'h00, 1'b0, 1'b1, 1'b1};
        step_out = {step_out, r};
      end
    end else begin
      foreach (step_bytes[k]) begin
        r.data   = step_bytes[k];
        r.bvalid = 1'b1;
        r.rlast  = (k == step_bytes.size() - 1);
        r.tend   = r.rlast && eot;
        step_out = {step_out, r};
      end
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_chars(input string s, input bit mix);
    logic [7:0] c;
    for (int k = 0; k < s.len(); k++) begin
      c = s[k];
      if (mix && c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'h20;
      seq_bytes = {seq_bytes, c};
    end
  endfunction

  function automatic void push_name(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = name_set[$urandom_range(0, name_set.len() - 1)];
      seq_bytes = {seq_bytes, c};
    end
  endfunction

  function automatic void push_digits(input int n, input bit hx);
    logic [7:0] c;
    repeat (n) begin
      c = hex_set[$urandom_range(0, hx ? 15 : 9)];
      if (c >= "a" && $urandom_range(0, 1) == 1) c = c - 8'h20;
      seq_bytes = {seq_bytes, c};
    end
  endfunction

  function automatic logic [31:0] rand_cp();
    case ($urandom_range(0, 7))
      0: return $urandom_range(1, 'h7F);
      1: return $urandom_range('h80, 'h7FF);
      2: return $urandom_range('h800, 'hFFFF);
      3: return $urandom_range('h10000, 'h10FFFF);
      4: return $urandom_range('hD800, 'hDFFF);
      5: return $urandom_range('h110000, 'hFFFF_FFFF);
      6: return $urandom_range(1, 3);
      default: begin
        // encoding and range boundaries
        case ($urandom_range(0, 9))
          0: return 32'h7F;
          1: return 32'h80;
          2: return 32'h7FF;
          3: return 32'h800;
          4: return 32'hD7FF;
          5: return 32'hE000;
          6: return 32'hFFFF;
          7: return 32'h10000;
          8: return 32'h10FFFF;
          default: return 32'h110000;
        endcase
      end
    endcase
  endfunction

  // One random text fragment: plain text, well-formed or malformed references
  function automatic void build_seq();
    logic [31:0] cp;
    logic [7:0]  c;
    string       s, xs;
    seq_bytes.delete();
    seq_end_last = 1'b0;
    xs = ($urandom_range(0, 1) == 1) ? "x" : "X";
    case ($urandom_range(0, 11))
      0: begin
        repeat ($urandom_range(1, 6)) begin
          c = 8'($urandom_range(0, 255));
          seq_bytes = {seq_bytes, c};
        end
      end
      1: begin
        repeat ($urandom_range(1, 8)) begin
          c = 8'($urandom_range(8'h20, 8'h7E));
          if (c == xed_pkg::CH_AMP) c = "a";
          seq_bytes = {seq_bytes, c};
        end
      end
      2, 3: begin
        case ($urandom_range(0, 4))
          0: s = "amp";
          1: s = "lt";
          2: s = "gt";
          3: s = "quot";
          default: s = "apos";
        endcase
        push_chars({"&", s, ";"}, 1'b1);
      end
      4: begin
        cp = rand_cp();
        push_chars("&#", 1'b0);
        if ($urandom_range(0, 3) == 0) push_chars("00", 1'b0);
        push_chars({$sformatf("%0d", cp), ";"}, 1'b0);
      end
      5: begin
        cp = rand_cp();
        push_chars({"&#", xs}, 1'b0);
        if ($urandom_range(0, 3) == 0) push_chars("0", 1'b0);
        push_chars({$sformatf("%0h", cp), ";"}, 1'b1);
      end
      6: begin
        // accumulator wraps
        if ($urandom_range(0, 1) == 1) begin
          push_chars("&#", 1'b0);
          push_digits($urandom_range(10, 12), 1'b0);
        end else begin
          push_chars({"&#", xs}, 1'b0);
          push_digits($urandom_range(9, 11), 1'b1);
        end
        push_chars(";", 1'b0);
      end
      7: begin
        case ($urandom_range(0, 4))
          0: push_chars("&#;", 1'b0);
          1: push_chars({"&#", xs, ";"}, 1'b0);
          2: begin
            push_chars("&#", 1'b0);
            push_digits($urandom_range(0, 3), 1'b0);
            c = 8'($urandom_range("a", "z"));
            seq_bytes = {seq_bytes, c};
            push_digits($urandom_range(0, 2), 1'b0);
            push_chars(";", 1'b0);
          end
          3: begin
            push_chars({"&#", xs}, 1'b0);
            push_digits($urandom_range(0, 3), 1'b1);
            c = 8'($urandom_range("g", "z"));
            seq_bytes = {seq_bytes, c};
            push_chars(";", 1'b0);
          end
          default: begin
            if ($urandom_range(0, 1) == 1) push_chars("&#", 1'b0);
            else push_chars({"&#", xs}, 1'b0);
            repeat ($urandom_range(1, 3)) push_chars("0", 1'b0);
            push_chars(";", 1'b0);
          end
        endcase
      end
      8: begin
        // unknown, empty and overlong names
        seq_bytes = {seq_bytes, xed_pkg::CH_AMP};
        if ($urandom_range(0, 3) == 0) push_name($urandom_range(NAME_MAX - 2, NAME_MAX + 3));
        else push_name($urandom_range(0, 6));
        seq_bytes = {seq_bytes, xed_pkg::CH_SEMI};
      end
      9: begin
        seq_bytes = {seq_bytes, xed_pkg::CH_AMP};
        push_name($urandom_range(0, 5));
        do c = 8'($urandom_range(0, 255)); while (is_nc(c) || c == xed_pkg::CH_SEMI);
        seq_bytes = {seq_bytes, c};
      end
      10: begin
        case ($urandom_range(0, 7))
          0: s = "ampx";
          1: s = "am";
          2: s = "l";
          3: s = "quo";
          4: s = "aposs";
          5: s = "gtt";
          6: s = "#x";
          default: s = "ltgt";
        endcase
        push_chars({"&", s, ";"}, 1'b1);
      end
      default: begin
        // text ends inside an entity
        seq_bytes = {seq_bytes, xed_pkg::CH_AMP};
        push_name($urandom_range(0, 4));
        seq_end_last = 1'b1;
      end
    endcase
  endfunction

  // Offer one byte, wait for the handshake, then log what it should produce
  task automatic send_item(input logic [7:0] b, input logic eot, input logic typed,
                           input out_item_t want);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = eot;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_step(b, eot);
    if (typed) decoded_due = {decoded_due, want};
    else foreach (step_out[k]) decoded_due = {decoded_due, step_out[k]};
    n_in++;
    if (eot) n_eot++;
    @(negedge clk_i);
  endtask

  // Main sequence: reset, directed table, random fragments, drain
  initial begin
    dir_row_t    row;
    logic        eot;
    int unsigned n_rand;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    ent_open      = 1'b0;
    name_len      = 0;
    code_val      = '0;
    digits_good   = 1'b1;
    n_rand        = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_TAB[i];
      send_item(row.data, row.eot, row.typed,
                {row.w_data, row.w_valid, row.w_rlast, row.w_tend});
    end

    while (n_rand < RAND_ITEMS) begin
      build_seq();
      foreach (seq_bytes[k]) begin
        eot = ($urandom_range(0, 29) == 0) || (seq_end_last && k == seq_bytes.size() - 1);
        send_item(seq_bytes[k], eot, 1'b0, '0);
        n_rand++;
        // output hold-off, then a stretch with no idling on either side
        if (n_rand == 60) hold_req = 1'b1;
        if (n_rand == 120) idle_on = 1'b0;
        if (n_rand == 175) idle_on = 1'b1;
      end
    end
    s_axis_tvalid = 1'b0;

    while (decoded_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("covered %0d input bytes (%0d ending the text), %0d output transactions,",
             n_in, n_eot, n_out);
    $display("named and numeric references, broken and overlong names, %0d-cycle hold-off",
             HOLD_CYC);
    if (n_bad == 0 && decoded_due.size() == 0) begin
      $display("xml_entity_decoder_top regression: pass");
    end else begin
      $display("xml_entity_decoder_top regression: fail");
    end
    $finish;
  end

  // Output side ready with random stalls and one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        for (int c = 0; c < HOLD_CYC; c++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready = !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string what, input out_item_t want,
                               input out_item_t got);
    n_bad++;
    if (n_bad <= MAX_SHOWN) begin
      $display("mismatch (%s): expected byte %02h valid %0b last %0b end %0b,",
               what, want.data, want.bvalid, want.rlast, want.tend);
      $display("  got byte %02h valid %0b last %0b end %0b",
               got.data, got.bvalid, got.rlast, got.tend);
    end
  endtask

  // Compare every output transaction with the oldest owed result
  always @(posedge clk_i) begin : out_check
    out_item_t want, got;
    string     diff;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_out++;
      got = {m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
      if (decoded_due.size() == 0) begin
        flag_mismatch("nothing owed", '0, got);
      end else begin
        want = decoded_due.pop_front();
        diff = "";
        if (got.data !== want.data) diff = {diff, " out_byte"};
        if (got.bvalid !== want.bvalid) diff = {diff, " byte_valid"};
        if (got.rlast !== want.rlast) diff = {diff, " run_last"};
        if (got.tend !== want.tend) diff = {diff, " text_end"};
        if (diff != "") flag_mismatch(diff, want, got);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_run <= 0;
    end else if (idle_run >= WD_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results owed",
               idle_run, decoded_due.size());
      $display("xml_entity_decoder_top regression: fail");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

endmodule
